### design/tmtw_pkg.sv
// shared constants, codes and controller/datapath interface types for the text console writer
package tmtw_pkg;

    localparam int ROWS_DEFAULT    = 25;
    localparam int COLUMNS_DEFAULT = 80;

    localparam int CHAR_W      = 8;
    localparam int COLOUR_W    = 4;
    localparam int CELL_W      = 16;
    localparam int REG_INDEX_W = 1;

    localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'd32;
    localparam logic [COLOUR_W-1:0] RESET_FG     = 4'd7;
    localparam logic [COLOUR_W-1:0] RESET_BG     = 4'd0;
    localparam logic [CELL_W-1:0]   RESET_CELL   = {RESET_BG, RESET_FG, SPACE_CODE};

    localparam logic [REG_INDEX_W-1:0] REG_FOREGROUND = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_BACKGROUND = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic load_item;
        logic sweep_zero;
        logic clear_step;
        logic copy_step;
        logic fill_step;
        logic read_cell;
        logic next_line;
        logic put_char;
        logic out_load;
    } tmtw_cmd_t;

    typedef struct packed {
        logic sweep_last_copy;
        logic sweep_last;
        logic is_read;
        logic read_in_range;
        logic is_newline;
        logic wrap_pending;
        logic row_last;
    } tmtw_sts_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [COLOUR_W-1:0] bg,
        input logic [COLOUR_W-1:0] fg,
        input logic [CHAR_W-1:0]   ch
    );
        make_cell = {bg, fg, ch};
    endfunction

endpackage

### design/tmtw_ctrl.sv
// controller state machine sequencing clear, item handling, scroll and result hand-off
module tmtw_ctrl
    import tmtw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  tmtw_sts_t sts,
    output tmtw_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_CHAR,
        ST_COPY,
        ST_FILL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load_item  = 1'b1;
                    cmd.sweep_zero = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_read) begin
                    if (sts.read_in_range) begin
                        cmd.read_cell = 1'b1;
                        state_next    = ST_READ_WAIT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else if (sts.is_newline || sts.wrap_pending) begin
                    cmd.next_line = 1'b1;
                    if (sts.row_last) begin
                        state_next = ST_COPY;
                    end else if (sts.is_newline) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_CHAR;
                    end
                end else begin
                    state_next = ST_CHAR;
                end
            end
            ST_READ_WAIT: begin
                state_next = ST_FINISH;
            end
            ST_CHAR: begin
                cmd.put_char = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_COPY: begin
                cmd.copy_step = 1'b1;
                if (sts.sweep_last_copy) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = sts.is_newline ? ST_FINISH : ST_CHAR;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("result overwritten while stalled");

    // a scroll always runs its copy into the fill of the bottom line
    a_copy_to_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && sts.sweep_last_copy) |=> state_reg == ST_FILL)
        else $error("copy did not hand over to fill");

    // no item is taken before the screen clear has finished
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("item accepted during screen clear");

endmodule

### design/tmtw_datapath.sv
// datapath: screen memory, write stage, cursor, colour registers, item and result registers
module tmtw_datapath
    import tmtw_pkg::*;
#(
    parameter int ROWS    = ROWS_DEFAULT,
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROW_W   = $clog2(ROWS),
    parameter int COL_W   = $clog2(COLUMNS + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_opcode,
    input  logic [CHAR_W-1:0]      in_char_code,
    input  logic [ROW_W-1:0]       in_read_row,
    input  logic [COL_W-1:0]       in_read_column,
    input  logic                   cfg_write,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [COLOUR_W-1:0]    cfg_data,
    input  tmtw_cmd_t              cmd,
    output tmtw_sts_t              sts,
    output logic [CELL_W-1:0]      out_cell_value,
    output logic [ROW_W-1:0]       out_cursor_row,
    output logic [COL_W-1:0]       out_cursor_column,
    output logic                   out_scrolled
);

    localparam int CELLS       = ROWS * COLUMNS;
    localparam int COPY_CELLS  = (ROWS - 1) * COLUMNS;
    localparam int AW          = $clog2(CELLS);
    localparam logic [AW-1:0]      COLS_A       = AW'(COLUMNS);
    localparam logic [AW-1:0]      SWEEP_END    = AW'(CELLS - 1);
    localparam logic [AW-1:0]      COPY_END     = AW'(COPY_CELLS - 1);
    localparam logic [ROW_W:0]     ROW_LIMIT    = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]   ROW_LAST     = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]   COL_LIMIT    = COL_W'(COLUMNS);
    localparam logic [AW:0]        CELLS_LIMIT  = (AW + 1)'(CELLS);

    logic [CELL_W-1:0] mem [CELLS];

    logic [COLOUR_W-1:0] fg_reg, bg_reg;
    logic                item_op_reg;
    logic [CHAR_W-1:0]   item_char_reg;
    logic [ROW_W-1:0]    item_row_reg;
    logic [COL_W-1:0]    item_col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic                scrolled_reg;
    logic [AW-1:0]       sweep_reg;

    logic                wr_en_reg, wr_en_next;
    logic                wr_copy_reg;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;
    logic [CELL_W-1:0]   wr_data_reg, wr_data_next;
    logic [CELL_W-1:0]   wr_cell;
    logic [CELL_W-1:0]   rdata_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       cursor_addr, read_addr;
    logic                read_in_range;

    logic [CELL_W-1:0]   out_cell_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic                out_scrolled_reg;

    assign cursor_addr   = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign read_addr     = AW'(item_row_reg) * COLS_A + AW'(item_col_reg);
    assign read_in_range = ({1'b0, item_row_reg} < ROW_LIMIT) && (item_col_reg < COL_LIMIT);

    assign sts.sweep_last_copy = (sweep_reg == COPY_END);
    assign sts.sweep_last      = (sweep_reg == SWEEP_END);
    assign sts.is_read         = (item_op_reg == OP_READ);
    assign sts.read_in_range   = read_in_range;
    assign sts.is_newline      = (item_char_reg == NEWLINE_CODE);
    assign sts.wrap_pending    = (col_reg == COL_LIMIT);
    assign sts.row_last        = (row_reg == ROW_LAST);

    // colour registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_FOREGROUND: fg_reg <= cfg_data;
                REG_BACKGROUND: bg_reg <= cfg_data;
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_op_reg   <= in_opcode;
            item_char_reg <= in_char_code;
            item_row_reg  <= in_read_row;
            item_col_reg  <= in_read_column;
        end
    end

    // cursor, scroll flag and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            scrolled_reg <= 1'b0;
            sweep_reg    <= '0;
        end else begin
            if (cmd.load_item) begin
                scrolled_reg <= 1'b0;
            end
            if (cmd.next_line) begin
                col_reg <= '0;
                if (row_reg == ROW_LAST) begin
                    scrolled_reg <= 1'b1;
                end else begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end
            if (cmd.put_char) begin
                col_reg <= col_reg + COL_W'(1);
            end
            if (cmd.sweep_zero) begin
                sweep_reg <= '0;
            end else if (cmd.clear_step || cmd.copy_step || cmd.fill_step) begin
                sweep_reg <= sweep_reg + AW'(1);
            end
        end
    end

    // write stage feeding the single memory write port
    always_comb begin
        wr_en_next   = cmd.clear_step || cmd.copy_step || cmd.fill_step || cmd.put_char;
        wr_addr_next = cmd.put_char ? cursor_addr : sweep_reg;
        if (cmd.clear_step) begin
            wr_data_next = RESET_CELL;
        end else if (cmd.fill_step) begin
            wr_data_next = make_cell(bg_reg, fg_reg, SPACE_CODE);
        end else begin
            wr_data_next = make_cell(bg_reg, fg_reg, item_char_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_en_reg   <= 1'b0;
            wr_copy_reg <= 1'b0;
        end else begin
            wr_en_reg   <= wr_en_next;
            wr_copy_reg <= cmd.copy_step;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= wr_data_next;
    end

    assign wr_cell = wr_copy_reg ? rdata_reg : wr_data_reg;
    assign rd_en   = cmd.copy_step || cmd.read_cell;
    assign rd_addr = cmd.copy_step ? (sweep_reg + COLS_A) : read_addr;

    // screen memory
    always_ff @(posedge aclk) begin
        if (wr_en_reg) begin
            mem[wr_addr_reg] <= wr_cell;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_cell_reg     <= (sts.is_read && read_in_range) ? rdata_reg : '0;
            out_row_reg      <= row_reg;
            out_col_reg      <= col_reg;
            out_scrolled_reg <= scrolled_reg;
        end
    end

    assign out_cell_value    = out_cell_reg;
    assign out_cursor_row    = out_row_reg;
    assign out_cursor_column = out_col_reg;
    assign out_scrolled      = out_scrolled_reg;

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, row_reg} < ROW_LIMIT)
        else $error("cursor row beyond screen");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_LIMIT)
        else $error("cursor column beyond wrap point");

    a_wr_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en_reg |-> ({1'b0, wr_addr_reg} < CELLS_LIMIT))
        else $error("screen write outside memory");

    // a scroll leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        scrolled_reg |-> (row_reg == ROW_LAST))
        else $error("scroll with cursor off the last row");

endmodule

### design/text_mode_terminal_writer.sv
// top level of the text console writer: stream packing and controller/datapath wiring
//
// Input items arrive on the s_ stream: s_tuser carries the opcode (write character or
// read cell), s_tdata the character byte and the row and column of a read. Each item
// gives exactly one result on the m_ stream with the cell read (zero for writes and for
// out-of-range reads), the cursor position after the item and a scroll flag. Colours are
// set through the cfg_ write channel (index 0 foreground, index 1 background), always ready.
// A character write or an in-range read without scroll goes from one accepted transaction
// to the next through these steps: accept, decode, memory access, load of the result
// register. A newline or an out-of-range read has no memory access step. A scroll adds
// the one-cell-per-cycle copy of the screen memory and the fill of the bottom line.
// After reset the block walks the whole screen memory, one cell a cycle, writing spaces
// in light grey on black; s_tready stays low until that is done.
// Results sit in an output register: while the receiver stalls the next item is still
// accepted and handled, and only waits before loading its result.
module text_mode_terminal_writer
    import tmtw_pkg::*;
#(
    parameter int ROWS    = ROWS_DEFAULT,
    parameter int COLUMNS = COLUMNS_DEFAULT,
    localparam int ROW_W    = $clog2(ROWS),
    localparam int COL_W    = $clog2(COLUMNS + 1),
    localparam int S_USED   = CHAR_W + ROW_W + COL_W,
    localparam int S_DATA_W = ((S_USED + 7) / 8) * 8,
    localparam int M_USED   = CELL_W + ROW_W + COL_W + 1,
    localparam int M_DATA_W = ((M_USED + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // char_code, read_row, read_column
    input  logic [0:0]             s_tuser,   // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,   // cell_value, cursor_row, cursor_column, scrolled
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [COLOUR_W-1:0]    cfg_data
);

    localparam int S_ROW_LO = CHAR_W;
    localparam int S_COL_LO = CHAR_W + ROW_W;

    tmtw_cmd_t            cmd;
    tmtw_sts_t            sts;
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_W-1:0]     cursor_row;
    logic [COL_W-1:0]     cursor_column;
    logic                 scrolled;

    assign cfg_ready = 1'b1;

    tmtw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tmtw_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .ROW_W   (ROW_W),
        .COL_W   (COL_W)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_opcode         (s_tuser[0]),
        .in_char_code      (s_tdata[CHAR_W-1:0]),
        .in_read_row       (s_tdata[S_ROW_LO +: ROW_W]),
        .in_read_column    (s_tdata[S_COL_LO +: COL_W]),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .sts               (sts),
        .out_cell_value    (cell_value),
        .out_cursor_row    (cursor_row),
        .out_cursor_column (cursor_column),
        .out_scrolled      (scrolled)
    );

    always_comb begin
        m_tdata             = '0;
        m_tdata[M_USED-1:0] = {scrolled, cursor_column, cursor_row, cell_value};
    end

endmodule
